// ===== rtl/tpu_pkg.sv =====
`timescale 1ns / 1ps

package tpu_pkg;

  localparam int CHANNELS_DEF = 64;
  localparam int ROW_BITS_DEF = 8;

  localparam logic [7:0] NOTE_NONE = 8'd253;
  localparam logic [7:0] VOL_NONE  = 8'd255;

  localparam logic [7:0] MASK_NEW_BIT  = 8'h80;
  localparam logic [7:0] CHAN_MASK     = 8'h7F;
  localparam logic [7:0] HAS_NOTE      = 8'h11;
  localparam logic [7:0] HAS_INS       = 8'h22;
  localparam logic [7:0] HAS_VOL       = 8'h44;
  localparam logic [7:0] HAS_EFFECT    = 8'h88;

  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 48;

  // Remembered per-channel state: mask plus the five last field bytes.
  typedef struct packed {
    logic [7:0] effect_param;
    logic [7:0] effect;
    logic [7:0] volume;
    logic [7:0] instrument;
    logic [7:0] note;
    logic [7:0] mask;
  } slot_word_t;

  typedef struct packed {
    logic       row_end;
    logic [5:0] channel;
    logic [7:0] note;
    logic [7:0] instrument;
    logic [7:0] volume;
    logic [7:0] effect;
    logic [7:0] effect_param;
    logic       bad_channel;
  } result_t;

endpackage

// ===== rtl/tpu_slot_ram.sv =====
`timescale 1ns / 1ps

module tpu_slot_ram #(
  parameter int SLOTS  = 65,
  parameter int ADDR_W = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  tpu_pkg::slot_word_t wr_word,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output tpu_pkg::slot_word_t rd_word
);

  tpu_pkg::slot_word_t mem [SLOTS];
  logic [SLOTS-1:0]    valid;

  tpu_pkg::slot_word_t rd_q;
  tpu_pkg::slot_word_t byp_word;
  logic                byp;
  logic                rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      byp_word <= wr_word;
    end
  end

  // A slot that was never written reads as zero; a write in the same cycle as
  // the read is forwarded so the reader sees the newest contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      byp    <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        byp    <= wr_en && (wr_addr == rd_addr);
        rd_vld <= valid[rd_addr];
      end
    end
  end

  assign rd_word = byp ? byp_word : (rd_vld ? rd_q : '0);

endmodule

// ===== rtl/tpu_parser.sv =====
`timescale 1ns / 1ps

module tpu_parser #(
  parameter int CHANNELS = tpu_pkg::CHANNELS_DEF,
  parameter int ROW_BITS = tpu_pkg::ROW_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tpu_pkg::S_DATA_W-1:0]    s_tdata,
  input  logic                            s_tuser,
  input  logic                            out_free,
  output logic                            out_load,
  output tpu_pkg::result_t                out_res
);

  localparam int SLOTS  = CHANNELS + 1;
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP_W  = (ROW_BITS > 8) ? ROW_BITS : 8;
  localparam logic [ROW_BITS-1:0] ROW_MAX = {ROW_BITS{1'b1}};

  typedef enum logic [2:0] {
    PH_CHAN, PH_MASK, PH_NOTE, PH_INS, PH_VOL, PH_EFT, PH_EFP
  } phase_t;

  function automatic phase_t next_phase(input logic [7:0] mask, input phase_t from);
    phase_t ph;
    ph = PH_CHAN;
    if (from <= PH_EFT && mask[3]) ph = PH_EFT;
    if (from <= PH_VOL && mask[2]) ph = PH_VOL;
    if (from <= PH_INS && mask[1]) ph = PH_INS;
    if (from <= PH_NOTE && mask[0]) ph = PH_NOTE;
    return ph;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_of(input logic [6:0] chn);
    if ({1'b0, chn} < 8'(CHANNELS)) begin
      return ADDR_W'(chn);
    end
    return ADDR_W'(CHANNELS);
  endfunction

  // Input register
  logic                in_valid;
  logic                in_kind;
  logic [7:0]          in_byte;
  logic [7:0]          in_wanted;

  // Decoder state
  phase_t              phase;
  logic [ROW_BITS-1:0] row;
  logic [6:0]          cur_chan;
  logic [ADDR_W-1:0]   cur_slot;
  tpu_pkg::slot_word_t cur_word;

  phase_t              phase_next;
  logic [ROW_BITS-1:0] row_next;
  logic [6:0]          chan_next;
  logic [ADDR_W-1:0]   slot_next;
  tpu_pkg::slot_word_t word_next;

  logic                accept;
  logic                process;
  logic                finish;
  logic                row_hit;
  logic                emit;
  tpu_pkg::result_t    res;

  logic                wr_en;
  logic [ADDR_W-1:0]   rd_addr;
  tpu_pkg::slot_word_t rd_word;
  logic [7:0]          s_chan_byte;

  assign process  = in_valid && out_free;
  assign s_tready = !in_valid || process;
  assign accept   = s_tvalid && s_tready;

  // Every incoming byte is looked up as if it were a channel byte; the result
  // is only used when it is one.
  assign s_chan_byte = (s_tdata[7:0] - 8'd1) & tpu_pkg::CHAN_MASK;
  assign rd_addr     = slot_of(s_chan_byte[6:0]);

  tpu_slot_ram #(
    .SLOTS  (SLOTS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (cur_slot),
    .wr_word (word_next),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_word (rd_word)
  );

  assign row_hit = CMP_W'(row) == CMP_W'(in_wanted);

  always_comb begin
    logic [7:0] chb;
    phase_next = phase;
    row_next   = row;
    chan_next  = cur_chan;
    slot_next  = cur_slot;
    word_next  = cur_word;
    wr_en      = 1'b0;
    finish     = 1'b0;
    emit       = 1'b0;
    res        = '0;
    chb        = (in_byte - 8'd1) & tpu_pkg::CHAN_MASK;

    if (in_kind) begin
      phase_next = PH_CHAN;
      chan_next  = '0;
      row_next   = '0;
    end else begin
      unique case (phase)
        PH_CHAN: begin
          if (in_byte == 8'd0) begin
            emit        = row_hit;
            res.row_end = 1'b1;
            if (row != ROW_MAX) begin
              row_next = row + ROW_BITS'(1);
            end
          end else begin
            chan_next = chb[6:0];
            slot_next = slot_of(chb[6:0]);
            word_next = rd_word;
            if ((in_byte & tpu_pkg::MASK_NEW_BIT) != 8'd0) begin
              phase_next = PH_MASK;
            end else begin
              phase_next = next_phase(rd_word.mask, PH_NOTE);
              finish     = (phase_next == PH_CHAN);
            end
          end
        end
        PH_MASK: begin
          word_next.mask = in_byte;
          wr_en          = 1'b1;
          phase_next     = next_phase(in_byte, PH_NOTE);
          finish         = (phase_next == PH_CHAN);
        end
        PH_NOTE: begin
          word_next.note = in_byte;
          wr_en          = 1'b1;
          phase_next     = next_phase(cur_word.mask, PH_INS);
          finish         = (phase_next == PH_CHAN);
        end
        PH_INS: begin
          word_next.instrument = in_byte;
          wr_en                = 1'b1;
          phase_next           = next_phase(cur_word.mask, PH_VOL);
          finish               = (phase_next == PH_CHAN);
        end
        PH_VOL: begin
          word_next.volume = in_byte;
          wr_en            = 1'b1;
          phase_next       = next_phase(cur_word.mask, PH_EFT);
          finish           = (phase_next == PH_CHAN);
        end
        PH_EFT: begin
          word_next.effect = in_byte;
          wr_en            = 1'b1;
          phase_next       = PH_EFP;
        end
        PH_EFP: begin
          word_next.effect_param = in_byte;
          wr_en                  = 1'b1;
          phase_next             = PH_CHAN;
          finish                 = 1'b1;
        end
        default: begin
          phase_next = PH_CHAN;
        end
      endcase
    end

    if (finish) begin
      emit        = row_hit;
      res.channel = chan_next[5:0];
      res.note    = ((word_next.mask & tpu_pkg::HAS_NOTE) != 8'd0) ?
                    word_next.note : tpu_pkg::NOTE_NONE;
      res.instrument = ((word_next.mask & tpu_pkg::HAS_INS) != 8'd0) ?
                       word_next.instrument : 8'd0;
      res.volume  = ((word_next.mask & tpu_pkg::HAS_VOL) != 8'd0) ?
                    word_next.volume : tpu_pkg::VOL_NONE;
      if ((word_next.mask & tpu_pkg::HAS_EFFECT) != 8'd0) begin
        res.effect       = word_next.effect;
        res.effect_param = word_next.effect_param;
      end
      res.bad_channel = ({1'b0, chan_next} >= 8'(CHANNELS));
    end

    // Nothing moves unless the item is actually taken this cycle.
    if (!process) begin
      wr_en = 1'b0;
    end
  end

  assign out_load = process && emit;
  assign out_res  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      phase    <= PH_CHAN;
      row      <= '0;
      cur_chan <= '0;
    end else begin
      if (accept) begin
        in_valid <= 1'b1;
      end else if (process) begin
        in_valid <= 1'b0;
      end
      if (process) begin
        phase    <= phase_next;
        row      <= row_next;
        cur_chan <= chan_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_kind   <= s_tuser;
      in_byte   <= s_tdata[7:0];
      in_wanted <= s_tdata[15:8];
    end
    if (process) begin
      cur_slot <= slot_next;
      cur_word <= word_next;
    end
  end

endmodule

// ===== rtl/tpu_out_reg.sv =====
`timescale 1ns / 1ps

module tpu_out_reg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  tpu_pkg::result_t             res,
  output logic                         free,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [tpu_pkg::M_DATA_W-1:0] m_tdata,
  output logic                         m_tlast,
  output logic                         m_tuser
);

  tpu_pkg::result_t held;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {2'b00, held.effect_param, held.effect, held.volume,
                    held.instrument, held.note, held.channel};
  assign m_tlast = held.row_end;
  assign m_tuser = held.bad_channel;

endmodule

// ===== rtl/tracker_pattern_unpacker.sv =====
`timescale 1ns / 1ps

// Packed tracker pattern decoder.
// The input stream carries one pattern byte per item: s_tuser high restarts the
// pattern at row zero (the byte is ignored), otherwise s_tdata[7:0] is the next
// packed byte and s_tdata[15:8] the row whose channel events are reported.
// Each channel entry completed in the wanted row yields one output item with
// the note, instrument, volume and effect bytes (absent ones at their defaults);
// the end of the wanted row yields an item with m_tlast high and zero data.
// m_tuser flags a channel beyond the supported count.
// For an item that yields output, m_tvalid rises once the input register has
// held it and the decode step has loaded the output register. One item is
// accepted every cycle while the output register is free; the channel table is
// a memory whose registered read is started from the incoming byte, so a
// channel byte finds its mask when it reaches decode.
// Reset returns to the channel-byte phase at row zero and marks every channel
// slot as unwritten, which reads as zero.
// When m_tready is low the output register holds, the input register fills and
// s_tready drops; no item is lost or repeated.
module tracker_pattern_unpacker #(
  parameter int CHANNELS = tpu_pkg::CHANNELS_DEF,
  parameter int ROW_BITS = tpu_pkg::ROW_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [tpu_pkg::S_DATA_W-1:0] s_tdata,  // pattern_byte, wanted_row
  input  logic                         s_tuser,  // kind
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // channel, note, instrument, volume, effect, effect_param, zero pad
  output logic [tpu_pkg::M_DATA_W-1:0] m_tdata,
  output logic                         m_tlast,  // row_end
  output logic                         m_tuser   // bad_channel
);

  logic             out_free;
  logic             out_load;
  tpu_pkg::result_t out_res;

  tpu_parser #(
    .CHANNELS (CHANNELS),
    .ROW_BITS (ROW_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .out_free (out_free),
    .out_load (out_load),
    .out_res  (out_res)
  );

  tpu_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .res      (out_res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int ITEMS      = 950;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN      = 20;
  localparam int SLOTS      = tpu_pkg::CHANNELS_DEF + 1;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [2:0] {
    ST_CHANNEL, ST_MASK, ST_NOTE, ST_INSTR, ST_VOLUME, ST_EFFECT, ST_PARAM
  } parse_state_t;

  // Tracks the decoder state byte by byte and holds the channel events and
  // row markers that the block still owes.
  class row_event_ledger;
    parse_state_t                     phase;
    logic [6:0]                       chan;
    logic [tpu_pkg::ROW_BITS_DEF-1:0] row;
    logic [7:0]                       mask_mem  [SLOTS];
    logic [7:0]                       note_mem  [SLOTS];
    logic [7:0]                       instr_mem [SLOTS];
    logic [7:0]                       vol_mem   [SLOTS];
    logic [7:0]                       fx_mem    [SLOTS];
    logic [7:0]                       fxp_mem   [SLOTS];
    tpu_pkg::result_t                 awaited_events[$];
    int                               mismatches;

    function new();
      phase = ST_CHANNEL;
      chan = '0;
      row = '0;
      mismatches = 0;
      for (int i = 0; i < SLOTS; i++) begin
        mask_mem[i] = '0;
        note_mem[i] = '0;
        instr_mem[i] = '0;
        vol_mem[i] = '0;
        fx_mem[i] = '0;
        fxp_mem[i] = '0;
      end
    endfunction

    function int slot_of(logic [6:0] c);
      return (c < tpu_pkg::CHANNELS_DEF) ? int'(c) : tpu_pkg::CHANNELS_DEF;
    endfunction

    // First field at or after 'from' that the mask brings in; none means the
    // entry is complete.
    function parse_state_t field_after(logic [7:0] mask, parse_state_t from);
      if (from <= ST_NOTE && mask[0]) return ST_NOTE;
      if (from <= ST_INSTR && mask[1]) return ST_INSTR;
      if (from <= ST_VOLUME && mask[2]) return ST_VOLUME;
      if (from <= ST_EFFECT && mask[3]) return ST_EFFECT;
      return ST_CHANNEL;
    endfunction

    function tpu_pkg::result_t channel_event(int s);
      tpu_pkg::result_t r;
      logic [7:0] m;
      m = mask_mem[s];
      r = '0;
      r.channel = chan[5:0];
      r.note = ((m & tpu_pkg::HAS_NOTE) != 0) ? note_mem[s] : tpu_pkg::NOTE_NONE;
      r.instrument = ((m & tpu_pkg::HAS_INS) != 0) ? instr_mem[s] : 8'd0;
      r.volume = ((m & tpu_pkg::HAS_VOL) != 0) ? vol_mem[s] : tpu_pkg::VOL_NONE;
      if ((m & tpu_pkg::HAS_EFFECT) != 0) begin
        r.effect = fx_mem[s];
        r.effect_param = fxp_mem[s];
      end
      r.bad_channel = (chan >= tpu_pkg::CHANNELS_DEF);
      return r;
    endfunction

    function void take_byte(logic kind, logic [7:0] b, logic [7:0] wanted);
      int s;
      tpu_pkg::result_t r;
      s = slot_of(chan);
      if (kind == KIND_RESTART) begin
        phase = ST_CHANNEL;
        chan = '0;
        row = '0;
        return;
      end
      unique case (phase)
        ST_CHANNEL: begin
          if (b == 8'd0) begin
            if (row == wanted) begin
              r = '0;
              r.row_end = 1'b1;
              awaited_events.push_back(r);
            end
            if (row != '1) row++;
            return;
          end
          chan = 7'((b - 8'd1) & tpu_pkg::CHAN_MASK);
          s = slot_of(chan);
          if ((b & tpu_pkg::MASK_NEW_BIT) != 0) begin
            phase = ST_MASK;
            return;
          end
          phase = field_after(mask_mem[s], ST_NOTE);
        end
        ST_MASK: begin
          mask_mem[s] = b;
          phase = field_after(b, ST_NOTE);
        end
        ST_NOTE: begin
          note_mem[s] = b;
          phase = field_after(mask_mem[s], ST_INSTR);
        end
        ST_INSTR: begin
          instr_mem[s] = b;
          phase = field_after(mask_mem[s], ST_VOLUME);
        end
        ST_VOLUME: begin
          vol_mem[s] = b;
          phase = field_after(mask_mem[s], ST_EFFECT);
        end
        ST_EFFECT: begin
          fx_mem[s] = b;
          phase = ST_PARAM;
          return;
        end
        ST_PARAM: begin
          fxp_mem[s] = b;
          phase = ST_CHANNEL;
        end
        default: begin
          phase = ST_CHANNEL;
          return;
        end
      endcase
      if (phase == ST_CHANNEL && row == wanted)
        awaited_events.push_back(channel_event(s));
    endfunction

    function string describe(tpu_pkg::result_t r);
      return $sformatf("end=%0d ch=%0d note=%0d ins=%0d vol=%0d fx=%0d fxp=%0d bad=%0d",
                       r.row_end, r.channel, r.note, r.instrument, r.volume,
                       r.effect, r.effect_param, r.bad_channel);
    endfunction

    function void match_event(tpu_pkg::result_t got);
      tpu_pkg::result_t want;
      if (awaited_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event: %s", describe(got));
        return;
      end
      want = awaited_events.pop_front();
      if (got.row_end !== want.row_end || got.channel !== want.channel ||
          got.note !== want.note || got.instrument !== want.instrument ||
          got.volume !== want.volume || got.effect !== want.effect ||
          got.effect_param !== want.effect_param ||
          got.bad_channel !== want.bad_channel) begin
        mismatches++;
        if (mismatches <= 10)
          $display("event differs: expected %s, got %s", describe(want), describe(got));
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [tpu_pkg::S_DATA_W-1:0] s_tdata;
  logic                         s_tuser;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [tpu_pkg::M_DATA_W-1:0] m_tdata;
  logic                         m_tlast;
  logic                         m_tuser;

  row_event_ledger ledger;
  int              items_sent;
  int              idle_cycles;
  bit              calm;

  tracker_pattern_unpacker u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int pause_len();
    return calm ? 0 : int'($urandom_range(0, 9));
  endfunction

  // Mostly aim at the row being decoded so that events actually come out.
  function automatic logic [7:0] pick_wanted();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return ledger.row;
    if (r < 8) return ledger.row + 8'd1;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send(input logic kind, input logic [7:0] data, input logic [7:0] wanted);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {wanted, data};
    do @(posedge clk); while (!s_tready);
    ledger.take_byte(kind, data, wanted);
    items_sent++;
  endtask

  // One channel entry: the channel byte, then whatever bytes the mask asks
  // for, now and then cut short by a restart.
  task automatic send_entry();
    logic [6:0] chan;
    logic [7:0] head;
    bit         fresh;
    chan = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(0, 63))
                                       : 7'($urandom_range(64, 127));
    fresh = (chan == 7'd127) || ($urandom_range(0, 2) != 0);
    head = {1'b0, chan} + 8'd1;
    if (fresh) head = (head & tpu_pkg::CHAN_MASK) | tpu_pkg::MASK_NEW_BIT;
    send(KIND_DATA, head, pick_wanted());
    while (ledger.phase != ST_CHANNEL) begin
      if ($urandom_range(0, 49) == 0)
        send(KIND_RESTART, 8'($urandom), pick_wanted());
      else
        send(KIND_DATA, 8'($urandom), pick_wanted());
    end
  endtask

  initial begin
    logic [7:0] opening [0:26];
    int         pick;
    bit         climbed;
    ledger = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    calm = 1'b0;
    climbed = 1'b0;
    items_sent = 0;
    // All fields on channel 0 at the byte extremes, reuse-only mask on the
    // top good channel, empty mask, remembered mask, then the channels beyond
    // the supported count sharing the scratch slot, the row end and a row
    // past the wanted one.
    opening = '{8'h81, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01,
                8'hC0, 8'hF0,
                8'h82, 8'h00,
                8'h01, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A,
                8'hFF, 8'h03, 8'hAA, 8'h55,
                8'h80, 8'h00,
                8'h41,
                8'h00, 8'h00, 8'h00};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(KIND_RESTART, 8'hFF, 8'h00);
    foreach (opening[i]) send(KIND_DATA, opening[i], 8'h00);

    while (items_sent < ITEMS) begin
      if ($urandom_range(0, 59) == 0) calm = !calm;
      pick = $urandom_range(0, 99);
      if (!climbed && items_sent > ITEMS / 2) begin
        // Run the row counter into saturation and keep reporting there.
        climbed = 1'b1;
        while (ledger.row != '1)
          send(KIND_DATA, 8'h00, ($urandom_range(0, 7) == 0) ? ledger.row : 8'($urandom));
        repeat (3) send(KIND_DATA, 8'h00, 8'hFF);
      end else if (pick < 4) begin
        send(KIND_RESTART, 8'($urandom), pick_wanted());
      end else if (pick < 16) begin
        send(KIND_DATA, 8'h00, pick_wanted());
      end else begin
        send_entry();
      end
    end
    s_tvalid <= 1'b0;

    while (ledger.awaited_events.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.awaited_events.size() == 0) begin
      $display("tracker_pattern_unpacker: match");
    end else begin
      $display("tracker_pattern_unpacker: mismatch");
    end
    $finish;
  end

  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = pause_len();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    tpu_pkg::result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.row_end = m_tlast;
      got.channel = m_tdata[5:0];
      got.note = m_tdata[13:6];
      got.instrument = m_tdata[21:14];
      got.volume = m_tdata[29:22];
      got.effect = m_tdata[37:30];
      got.effect_param = m_tdata[45:38];
      got.bad_channel = m_tuser;
      ledger.match_event(got);
    end
  end

  // Ends the run when neither side has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tracker_pattern_unpacker: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
